// ===== hdl/eplt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eplt_pkg
// Shared types and constants for the edge pattern learn table.
// ----------------------------------------------------------------------------
package eplt_pkg;

  // table geometry
  localparam int ENTRIES   = 16;
  localparam int DATA_W    = 16;
  localparam int TAG_W     = 8;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int OPV_W     = 2;
  localparam int STAT_W    = 2;

  // page tag under which no slot is learned; marks a free slot in the bench shadow
  localparam logic [TAG_W-1:0] EMPTY_TAG = '0;
  localparam logic [TAG_W-1:0] PAGE_RESET = TAG_W'(1);

  // operation codes
  typedef enum logic [OPV_W-1:0] {
    OP_READ   = 2'd0,
    OP_LEARN  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // status codes
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXISTS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_CREATED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd1;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // one slot of the record memory
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] rising;
    logic [DATA_W-1:0] change;
    logic [DATA_W-1:0] value;
  } rec_t;

endpackage : eplt_pkg
`default_nettype wire

// ===== hdl/edge_pattern_learn_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edge_pattern_learn_table
// Learnable table mapping input edge patterns to a held output word, with
// slot records in a simple dual-port synchronous memory scanned one slot a
// cycle.
// ----------------------------------------------------------------------------
// Timing: clear all, or an item with no input change, goes straight to done;
//   otherwise the controller scans the slots in order, comparing each slot
//   after its memory read, and the result register is loaded from done.
// Items: a new item is taken only in idle, after the last one is through; a
//   result held back by the receiver keeps the controller waiting in done.
// Reset: synchronous, active low; all slots free (valid flags cleared),
//   previous input, held output and count zero, page id 1. No clearing pass.
// ----------------------------------------------------------------------------
module edge_pattern_learn_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration: page_id
  input  wire logic                        cfg_wr_en,
  input  wire logic [eplt_pkg::TAG_W-1:0]  cfg_wr_data,
  // input stream
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [31:0]                 in_tdata,  // input_bits[15:0], learn_value[31:16]
  input  wire logic [1:0]                  in_tuser,  // op[1:0]
  // result stream
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [23:0]                 out_tdata, // output_value[15:0], entry_count[20:16]
  output      logic [1:0]                  out_tuser  // status[1:0]
);
  import eplt_pkg::*;

  // control and state registers
  state_t              state_r;
  logic [TAG_W-1:0]    page_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [CNT_W-1:0]    count_r;
  logic [DATA_W-1:0]   prev_r;
  logic [DATA_W-1:0]   held_r;
  logic                out_valid_r;

  // item payload registers
  op_t                 op_r;
  logic [DATA_W-1:0]   change_r;
  logic [DATA_W-1:0]   rising_r;
  logic [DATA_W-1:0]   value_r;
  logic [STAT_W-1:0]   status_r;

  // scan registers
  logic [CNT_W-1:0]    rd_idx_r;
  logic                cmp_vld_r;
  logic [IDX_W-1:0]    cmp_idx_r;

  // output registers
  logic [DATA_W-1:0]   out_value_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [CNT_W-1:0]    out_count_r;

  // record memory
  rec_t                rec_mem [ENTRIES];
  rec_t                rd_data_r;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  rec_t                wr_data;
  logic [IDX_W-1:0]    rd_addr;

  // input field unpacking
  logic                in_xfer;
  op_t                 in_op;
  logic [DATA_W-1:0]   in_bits;
  logic [DATA_W-1:0]   in_value;
  logic [DATA_W-1:0]   in_change;

  // compare and free slot search
  logic                hit;
  logic                last_cmp;
  logic                free_any;
  logic [IDX_W-1:0]    free_idx;
  logic                out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser[OPV_W-1:0]);
  assign in_bits   = in_tdata[DATA_W-1:0];
  assign in_value  = in_tdata[2*DATA_W-1:DATA_W];
  assign in_change = prev_r ^ in_bits;
  assign out_free  = !out_valid_r || out_tready;

  // compare of the slot read in the previous cycle
  assign hit = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data_r.tag == page_r) &&
               (rd_data_r.change == change_r) && (rd_data_r.rising == rising_r);
  assign last_cmp = cmp_vld_r && (cmp_idx_r == IDX_W'(ENTRIES - 1));

  // lowest free slot from the valid flags
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // memory access control
  assign rd_addr = rd_idx_r[IDX_W-1:0];
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = free_idx;
    wr_data.tag    = page_r;
    wr_data.rising = rising_r;
    wr_data.change = change_r;
    wr_data.value  = value_r;
    if ((state_r == S_SCAN) && (hit || last_cmp) && (op_r == OP_LEARN) && !hit &&
        (page_r != EMPTY_TAG) && free_any) begin
      wr_en = 1'b1;
    end
  end

  // record memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= rec_mem[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= PAGE_RESET;
    end else if (cfg_wr_en) begin
      page_r <= cfg_wr_data;
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      count_r   <= '0;
      prev_r    <= '0;
      held_r    <= '0;
      cmp_vld_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r      <= in_op;
            change_r  <= in_change;
            rising_r  <= in_change & in_bits;
            value_r   <= in_value;
            rd_idx_r  <= '0;
            cmp_vld_r <= 1'b0;
            if (in_op == OP_CLEAR) begin
              // free every slot at once
              valid_r  <= '0;
              count_r  <= '0;
              status_r <= (count_r != '0) ? ST_DONE : ST_NONE;
              state_r  <= S_DONE;
            end else begin
              prev_r <= in_bits;
              if (in_change == '0) begin
                status_r <= ST_NONE;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          // resolve on the first match or after the last slot
          if (hit || last_cmp) begin
            state_r   <= S_DONE;
            cmp_vld_r <= 1'b0;
            unique case (op_r)
              OP_READ: begin
                if (hit) begin
                  held_r <= rd_data_r.value;
                end
                status_r <= ST_NONE;
              end
              OP_LEARN: begin
                if (hit) begin
                  status_r <= ST_EXISTS;
                end else if ((page_r != EMPTY_TAG) && free_any) begin
                  valid_r[free_idx] <= 1'b1;
                  count_r           <= count_r + CNT_W'(1);
                  status_r          <= ST_CREATED;
                end else begin
                  status_r <= ST_FULL;
                end
              end
              OP_REMOVE: begin
                if (hit) begin
                  valid_r[cmp_idx_r] <= 1'b0;
                  if (count_r != '0) begin
                    count_r <= count_r - CNT_W'(1);
                  end
                  status_r <= ST_DONE;
                end else begin
                  status_r <= ST_NONE;
                end
              end
              default: begin
                status_r <= ST_NONE;
              end
            endcase
          end else if (rd_idx_r < CNT_W'(ENTRIES)) begin
            // issue the next slot read
            rd_idx_r  <= rd_idx_r + CNT_W'(1);
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= rd_idx_r[IDX_W-1:0];
          end else begin
            cmp_vld_r <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result register, loaded when the previous result has gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_value_r  <= held_r;
      out_status_r <= status_r;
      out_count_r  <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - DATA_W - CNT_W){1'b0}}, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule : edge_pattern_learn_table
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the edge pattern learn table. A behavioural copy of
// the table predicts every reply; replies are checked field by field as they
// leave the block. Directed items cover the corner cases. Randomised phases
// under several page tags follow, most with bursty idling on both streams.
// ----------------------------------------------------------------------------
module tb;

  import eplt_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RUN_LIMIT  = 5_000_000;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE_CYC = 20;

  // one reply of the table
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } reply_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [TAG_W-1:0]    cfg_wr_data = '0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata    = '0;  // input_bits[15:0], learn_value[31:16]
  logic [1:0]          in_tuser    = '0;  // op[1:0]
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [23:0]         out_tdata;         // output_value[15:0], entry_count[20:16]
  logic [1:0]          out_tuser;         // status[1:0]

  // shadow copy of the table
  logic [TAG_W-1:0]    shadow_tag    [ENTRIES];
  logic [DATA_W-1:0]   shadow_change [ENTRIES];
  logic [DATA_W-1:0]   shadow_rising [ENTRIES];
  logic [DATA_W-1:0]   shadow_value  [ENTRIES];
  logic [DATA_W-1:0]   shadow_prev   = '0;
  logic [DATA_W-1:0]   shadow_held   = '0;
  logic [CNT_W-1:0]    shadow_count  = '0;
  logic [TAG_W-1:0]    shadow_page   = PAGE_RESET;

  reply_t              replies_due[$];

  // idling controls
  bit                  tx_gaps_on  = 1'b0;
  bit                  rx_stall_on = 1'b0;
  bit                  hold_req    = 1'b0;

  // statistics
  int                  errors      = 0;
  int                  n_checked   = 0;
  int                  n_op[4]     = '{0, 0, 0, 0};
  int                  n_full      = 0;
  int                  n_created   = 0;
  int                  n_pages     = 0;

  edge_pattern_learn_table i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog
  initial begin
    #RUN_LIMIT;
    $display("run limit reached with %0d replies outstanding", replies_due.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_tag[i] = EMPTY_TAG;
    end
  end

  // mismatch reporting
  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // table behaviour: update the shadow and return the reply
  function automatic reply_t predict_table_reply(op_t op, logic [DATA_W-1:0] bits,
                                                 logic [DATA_W-1:0] val);
    reply_t            r;
    logic [DATA_W-1:0] chg;
    logic [DATA_W-1:0] rise;
    logic [STAT_W-1:0] st;
    int                hit;
    chg  = shadow_prev ^ bits;
    rise = chg & bits;
    st   = ST_NONE;
    hit  = -1;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_tag[i] != EMPTY_TAG) begin
          shadow_tag[i] = EMPTY_TAG;
          st = ST_DONE;
        end
      end
      shadow_count = '0;
    end else if (chg != '0) begin
      // lowest slot of the page holding the key
      if (shadow_page != EMPTY_TAG) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit < 0 && shadow_tag[i] == shadow_page && shadow_change[i] == chg &&
              shadow_rising[i] == rise) hit = i;
        end
      end
      case (op)
        OP_READ: begin
          if (hit >= 0) shadow_held = shadow_value[hit];
        end
        OP_LEARN: begin
          if (hit >= 0) begin
            st = ST_EXISTS;
          end else begin
            st = ST_FULL;
            if (shadow_page != EMPTY_TAG) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (st == ST_FULL && shadow_tag[i] == EMPTY_TAG) begin
                  shadow_tag[i]    = shadow_page;
                  shadow_change[i] = chg;
                  shadow_rising[i] = rise;
                  shadow_value[i]  = val;
                  shadow_count++;
                  st = ST_CREATED;
                end
              end
            end
          end
        end
        default: begin
          if (hit >= 0) begin
            shadow_tag[hit] = EMPTY_TAG;
            if (shadow_count > 0) shadow_count--;
            st = ST_DONE;
          end
        end
      endcase
      shadow_prev = bits;
    end
    r.value  = shadow_held;
    r.status = st;
    r.count  = shadow_count;
    return r;
  endfunction

  // offer one item and wait for its transfer; caller stands at a falling edge
  task automatic send_item(op_t op, logic [DATA_W-1:0] bits, logic [DATA_W-1:0] val);
    reply_t r;
    int     gap;
    gap = (tx_gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, bits};
    do @(posedge clk); while (!in_tready);
    r = predict_table_reply(op, bits, val);
    replies_due.push_back(r);
    n_op[op]++;
    if (op == OP_LEARN && r.status == ST_FULL) n_full++;
    if (op == OP_LEARN && r.status == ST_CREATED) n_created++;
    @(negedge clk);
  endtask

  // stop offering and wait for every reply, then let the block settle
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // page register write, block idle
  task automatic set_page(logic [TAG_W-1:0] page);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= page;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_page = page;
    n_pages++;
  endtask

  // result receiver with random stall bursts and long hold-off
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (stall_left == 0 && rx_stall_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 19);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // reply checker
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply, tdata", 0, int'(out_tdata));
      end else begin
        e = replies_due.pop_front();
        n_checked++;
        if (out_tdata[15:0] !== e.value)
          report_mismatch("output_value", int'(e.value), int'(out_tdata[15:0]));
        if (out_tuser !== e.status)
          report_mismatch("status", int'(e.status), int'(out_tuser));
        if (out_tdata[20:16] !== e.count)
          report_mismatch("entry_count", int'(e.count), int'(out_tdata[20:16]));
      end
    end
  end

  // no input change on every operation, clear on an empty table
  task automatic test_no_change();
    send_item(OP_READ, 16'h0000, 16'hFFFF);
    send_item(OP_LEARN, 16'h0000, 16'hFFFF);
    send_item(OP_REMOVE, 16'h0000, 16'h0000);
    send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF);
  endtask

  // fill every slot, then full, hit, exists, remove and clear
  task automatic test_fill_table();
    logic [DATA_W-1:0] v;
    for (int i = 0; i < ENTRIES; i++) begin
      v = (i == 0) ? 16'hFFFF : (i == ENTRIES - 1) ? 16'h0000 : DATA_W'($urandom);
      send_item(OP_LEARN, 16'hFFFF >> (15 - i), v);
    end
    send_item(OP_LEARN, 16'hFFFE, 16'h5A5A);
    send_item(OP_READ, 16'h0000, 16'h0000);
    send_item(OP_READ, 16'h0001, 16'h0000);
    send_item(OP_READ, 16'h0000, 16'h0000);
    send_item(OP_LEARN, 16'h0001, 16'hA5A5);
    send_item(OP_READ, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h0001, 16'h0000);
    send_item(OP_CLEAR, 16'h0000, 16'h0000);
  endtask

  // page zero matches nothing and cannot learn; entries keep their own page
  task automatic test_page_zero();
    set_page(EMPTY_TAG);
    send_item(OP_LEARN, ~shadow_prev, 16'h1234);
    send_item(OP_READ, ~shadow_prev, 16'h0000);
    send_item(OP_REMOVE, ~shadow_prev, 16'h0000);
    set_page(8'hFF);
    send_item(OP_LEARN, ~shadow_prev, 16'hFFFF);
    send_item(OP_LEARN, ~shadow_prev, 16'h0000);
    send_item(OP_READ, ~shadow_prev, 16'h0000);
  endtask

  // long receiver hold-off while items keep coming, then a full pause
  task automatic test_backpressure();
    set_page(PAGE_RESET);
    hold_req = 1'b1;
    tx_gaps_on = 1'b0;
    for (int i = 0; i < 12; i++) begin
      send_item(op_t'($urandom_range(0, 2)), DATA_W'($urandom), DATA_W'($urandom));
    end
    drain_replies();
    tx_gaps_on = 1'b1;
  endtask

  // random items over a small pool of input patterns so that keys recur
  task automatic run_random_phase(int n_items, logic [TAG_W-1:0] page, int clear_pct);
    logic [DATA_W-1:0] pool[8];
    logic [DATA_W-1:0] bits;
    int                sel;
    op_t               op;
    set_page(page);
    for (int k = 0; k < 8; k++) pool[k] = DATA_W'($urandom);
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < clear_pct)      op = OP_CLEAR;
      else if (sel < 40)        op = OP_READ;
      else if (sel < 78)        op = OP_LEARN;
      else                      op = OP_REMOVE;
      bits = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : DATA_W'($urandom);
      send_item(op, bits, DATA_W'($urandom));
    end
  endtask

  // test sequence
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;

    test_no_change();
    test_fill_table();
    test_page_zero();
    test_backpressure();

    run_random_phase(200, PAGE_RESET, 2);
    run_random_phase(200, 8'hFF, 1);
    run_random_phase(30, EMPTY_TAG, 3);
    run_random_phase(200, TAG_W'($urandom_range(2, 254)), 5);
    run_random_phase(200, 8'h02, 1);
    run_random_phase(200, PAGE_RESET, 3);
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    run_random_phase(200, 8'hFF, 2);

    // wait out the last replies
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (replies_due.size() != 0) report_mismatch("replies left over", 0, replies_due.size());

    $display("covered %0d reads, %0d learns, %0d removes, %0d clears over %0d page settings",
             n_op[OP_READ], n_op[OP_LEARN], n_op[OP_REMOVE], n_op[OP_CLEAR], n_pages);
    $display("%0d replies checked, %0d entries created, %0d table-full reports, %0d errors",
             n_checked, n_created, n_full, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : tb

// ===== files.f =====
hdl/eplt_pkg.sv
hdl/edge_pattern_learn_table.sv
test/tb.sv
